// ===== hdl/pcm_pkg.sv =====
// Shared types and constants for the correlation block.
package pcm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 11;
  localparam int MAX_SAMPLES = 1024;
  localparam int SUM_W       = 26;
  localparam int SQ_W        = 41;
  localparam int CROSS_W     = 42;
  localparam int THR_W       = 17;
  localparam int CORR_W      = 16;
  localparam int Q_ONE       = 16384;
  localparam int QBITS       = 15;
  localparam int BIT_W       = 4;
  localparam int NUM_W       = 56;
  localparam int MA_W        = 104;
  localparam int MB_W        = 56;
  localparam int MP_W        = 134;
  localparam int RHS_SHIFT   = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_CHECK,
    ST_TRY,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_AA,
    OP_BB,
    OP_AB,
    OP_NSAB,
    OP_SASB,
    OP_NSAA,
    OP_SASA,
    OP_NSBB,
    OP_SBSB,
    OP_VPROD,
    OP_NUMSQ,
    OP_KSQ,
    OP_LHS
  } mul_op_e;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [MP_W-1:0] p;
  } mul_rsp_t;

endpackage

// ===== hdl/pcm_mul.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
module pcm_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcm_pkg::mul_req_t req_i,
  output pcm_pkg::mul_rsp_t rsp_o
);
  import pcm_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [MP_W-1:0] a_q;
  logic [MB_W-1:0] b_q;
  logic [MP_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && (b_q[MB_W-1:1] == '0)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= MP_W'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[MP_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MB_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== hdl/pearson_correlation_missing.sv =====
// Pearson correlation of two Q8.8 series with missing samples; result in Q2.14.
//
// Each item is counted. A pair with neither sample missing is accumulated by a shared
// shift-and-add multiplier that retires one multiplier bit per cycle, using three
// 16-bit products; a missing pair needs no product. On the item flagged last, the same
// multiplier finds the coefficient: six moment products, the variance product and the
// squared numerator, then a 15-step bit search on the ratio. A tried step costs two
// products; a skipped step costs none. A series that fails the count or threshold
// check goes from the check straight to the output. s_axis_tready is low throughout.
// Up to 1024 pairs are kept per series; later pairs are ignored until the last mark.
module pearson_correlation_missing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample_a, sample_b
  input  logic [1:0]  s_axis_tuser,  // a_missing, b_missing
  input  logic        s_axis_tlast,  // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // correlation, pairs_used
  output logic [0:0]  m_axis_tuser,  // result_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pcm_pkg::THR_W-1:0] cfg_data_i
);
  import pcm_pkg::*;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic [THR_W-1:0] thr_q;
  logic signed [SAMPLE_W-1:0] item_a_q, item_b_q;
  logic last_q;
  logic [CNT_W-1:0] total_q, present_q;
  logic signed [SUM_W-1:0] sa_q, sb_q;
  logic [SQ_W-1:0] saa_q, sbb_q;
  logic signed [CROSS_W-1:0] sab_q;
  logic [MB_W-1:0] t1_q;
  logic signed [NUM_W-1:0] num_q, va_q, vb_q;
  logic [MA_W-1:0] vprod_q;
  logic [MP_W-1:0] rhs_q;
  logic [QBITS-1:0] q_q, cand_q;
  logic [BIT_W-1:0] bit_q;
  logic [CORR_W-1:0] res_corr_q;
  logic res_ok_q;
  logic out_valid_q, out_ok_q;
  logic [CORR_W-1:0] out_corr_q;
  logic [CNT_W-1:0] out_pairs_q;

  logic in_fire, out_load, counted, present;
  logic signed [SAMPLE_W-1:0] in_a, in_b;
  logic [SAMPLE_W-1:0] abs_a, abs_b;
  logic [SUM_W-1:0] abs_sa, abs_sb;
  logic [CROSS_W-1:0] abs_sab;
  logic [NUM_W-1:0] abs_num;
  logic [MB_W-1:0] p_lo;
  logic signed [NUM_W-1:0] diff, term1, term2;
  logic thr_ok, var_ok;
  logic [QBITS-1:0] cand;
  logic [QBITS:0] k;

  assign in_a    = s_axis_tdata[15:0];
  assign in_b    = s_axis_tdata[31:16];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign counted = total_q < CNT_W'(MAX_SAMPLES);
  assign present = counted && !s_axis_tuser[0] && !s_axis_tuser[1];
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign abs_a   = item_a_q[SAMPLE_W-1] ? SAMPLE_W'(-item_a_q) : SAMPLE_W'(item_a_q);
  assign abs_b   = item_b_q[SAMPLE_W-1] ? SAMPLE_W'(-item_b_q) : SAMPLE_W'(item_b_q);
  assign abs_sa  = sa_q[SUM_W-1] ? SUM_W'(-sa_q) : SUM_W'(sa_q);
  assign abs_sb  = sb_q[SUM_W-1] ? SUM_W'(-sb_q) : SUM_W'(sb_q);
  assign abs_sab = sab_q[CROSS_W-1] ? CROSS_W'(-sab_q) : CROSS_W'(sab_q);
  assign abs_num = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign p_lo    = mrsp.p[MB_W-1:0];
  assign diff    = $signed(t1_q) - $signed(p_lo);
  assign term1   = sab_q[CROSS_W-1] ? -$signed(t1_q) : $signed(t1_q);
  assign term2   = (sa_q[SUM_W-1] ^ sb_q[SUM_W-1]) ? -$signed(p_lo) : $signed(p_lo);
  // present/total >= thr/65536, cross-multiplied
  assign thr_ok  = (present_q >= CNT_W'(2)) &&
                   ({1'b0, present_q, 16'b0} >= (28'(thr_q) * 28'(total_q)));
  assign var_ok  = (!va_q[NUM_W-1] && va_q != '0) && (!diff[NUM_W-1] && diff != '0);
  assign cand    = q_q | (QBITS'(1) << bit_q);
  assign k       = {cand_q, 1'b0} - (QBITS+1)'(1);

  // multiplier operand select
  always_comb begin
    mreq.start = (state_q == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (op_q)
      OP_AA:    begin mreq.a = MA_W'(abs_a);   mreq.b = MB_W'(abs_a); end
      OP_BB:    begin mreq.a = MA_W'(abs_b);   mreq.b = MB_W'(abs_b); end
      OP_AB:    begin mreq.a = MA_W'(abs_a);   mreq.b = MB_W'(abs_b); end
      OP_NSAB:  begin mreq.a = MA_W'(abs_sab); mreq.b = MB_W'(present_q); end
      OP_SASB:  begin mreq.a = MA_W'(abs_sa);  mreq.b = MB_W'(abs_sb); end
      OP_NSAA:  begin mreq.a = MA_W'(saa_q);   mreq.b = MB_W'(present_q); end
      OP_SASA:  begin mreq.a = MA_W'(abs_sa);  mreq.b = MB_W'(abs_sa); end
      OP_NSBB:  begin mreq.a = MA_W'(sbb_q);   mreq.b = MB_W'(present_q); end
      OP_SBSB:  begin mreq.a = MA_W'(abs_sb);  mreq.b = MB_W'(abs_sb); end
      OP_VPROD: begin mreq.a = MA_W'(va_q);    mreq.b = MB_W'(vb_q); end
      OP_NUMSQ: begin mreq.a = MA_W'(abs_num); mreq.b = MB_W'(abs_num); end
      OP_KSQ:   begin mreq.a = MA_W'(k);       mreq.b = MB_W'(k); end
      OP_LHS:   begin mreq.a = vprod_q;        mreq.b = t1_q; end
      default:  begin mreq.a = '0;             mreq.b = '0; end
    endcase
  end

  pcm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (present) begin
            state_d = ST_ISSUE;
            op_d    = OP_AA;
          end else if (s_axis_tlast) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mrsp.done) begin
          state_d = ST_ISSUE;
          unique case (op_q)
            OP_AA:    op_d = OP_BB;
            OP_BB:    op_d = OP_AB;
            OP_AB:    state_d = last_q ? ST_CHECK : ST_IDLE;
            OP_NSAB:  op_d = OP_SASB;
            OP_SASB:  op_d = OP_NSAA;
            OP_NSAA:  op_d = OP_SASA;
            OP_SASA:  op_d = OP_NSBB;
            OP_NSBB:  op_d = OP_SBSB;
            OP_SBSB: begin
              if (var_ok) begin
                op_d = OP_VPROD;
              end else begin
                state_d = ST_OUT;
              end
            end
            OP_VPROD: op_d = OP_NUMSQ;
            OP_NUMSQ: state_d = ST_TRY;
            OP_KSQ:   op_d = OP_LHS;
            OP_LHS:   state_d = (bit_q == '0) ? ST_FIN : ST_TRY;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (thr_ok) begin
          state_d = ST_ISSUE;
          op_d    = OP_NSAB;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_TRY: begin
        if (cand > QBITS'(Q_ONE)) begin
          state_d = (bit_q == '0) ? ST_FIN : ST_TRY;
        end else begin
          state_d = ST_ISSUE;
          op_d    = OP_KSQ;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_AA;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      present_q   <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      saa_q       <= '0;
      sbb_q       <= '0;
      sab_q       <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && counted) begin
        total_q <= total_q + CNT_W'(1);
      end
      if (in_fire && present) begin
        present_q <= present_q + CNT_W'(1);
        sa_q      <= sa_q + SUM_W'(in_a);
        sb_q      <= sb_q + SUM_W'(in_b);
      end
      if (state_q == ST_WAIT && mrsp.done) begin
        unique case (op_q)
          OP_AA:   saa_q <= saa_q + mrsp.p[SQ_W-1:0];
          OP_BB:   sbb_q <= sbb_q + mrsp.p[SQ_W-1:0];
          OP_AB: begin
            if (item_a_q[SAMPLE_W-1] ^ item_b_q[SAMPLE_W-1]) begin
              sab_q <= sab_q - $signed(mrsp.p[CROSS_W-1:0]);
            end else begin
              sab_q <= sab_q + $signed(mrsp.p[CROSS_W-1:0]);
            end
          end
          default: ;
        endcase
      end
      if (out_load) begin
        total_q   <= '0;
        present_q <= '0;
        sa_q      <= '0;
        sb_q      <= '0;
        saa_q     <= '0;
        sbb_q     <= '0;
        sab_q     <= '0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_a_q <= in_a;
      item_b_q <= in_b;
      last_q   <= s_axis_tlast;
    end
    if (state_q == ST_CHECK) begin
      res_corr_q <= '0;
      res_ok_q   <= 1'b0;
    end
    if (state_q == ST_TRY) begin
      cand_q <= cand;
      if (cand > QBITS'(Q_ONE)) begin
        bit_q <= bit_q - BIT_W'(1);
      end
    end
    if (state_q == ST_WAIT && mrsp.done) begin
      unique case (op_q)
        OP_NSAB:  t1_q <= p_lo;
        OP_SASB:  num_q <= term1 - term2;
        OP_NSAA:  t1_q <= p_lo;
        OP_SASA:  va_q <= diff;
        OP_NSBB:  t1_q <= p_lo;
        OP_SBSB:  vb_q <= diff;
        OP_VPROD: vprod_q <= mrsp.p[MA_W-1:0];
        OP_NUMSQ: begin
          rhs_q <= {mrsp.p[MP_W-RHS_SHIFT-1:0], {RHS_SHIFT{1'b0}}};
          q_q   <= '0;
          bit_q <= BIT_W'(QBITS - 1);
        end
        OP_KSQ:   t1_q <= p_lo;
        OP_LHS: begin
          if (mrsp.p <= rhs_q) begin
            q_q <= cand_q;
          end
          bit_q <= bit_q - BIT_W'(1);
        end
        default: ;
      endcase
    end
    if (state_q == ST_FIN) begin
      res_corr_q <= num_q[NUM_W-1] ? CORR_W'(-{1'b0, q_q}) : CORR_W'(q_q);
      res_ok_q   <= 1'b1;
    end
    if (out_load) begin
      out_corr_q  <= res_corr_q;
      out_ok_q    <= res_ok_q;
      out_pairs_q <= present_q;
    end
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {5'b0, out_pairs_q, out_corr_q};
  assign m_axis_tuser[0] = out_ok_q;

endmodule

// ===== hdl/pcm_checker.sv =====
// Port-level checks for the correlation block, bound to the top level.
module pcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // the last item of a series always leaves the input not ready straight after it
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready straight after a last item");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[15:0] == 16'h0000))
    else $error("invalid result with non-zero coefficient");

  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("coefficient beyond one");

  a_pairs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[26:16] <= 11'd1024 && m_axis_tdata[31:27] == 5'd0))
    else $error("pair count out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind pearson_correlation_missing pcm_checker u_pcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/corr_checker.sv =====
// Checker for the correlation block: watches the streams, predicts each result and compares.
module corr_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,
  input  logic [1:0]                s_axis_tuser,
  input  logic                      s_axis_tlast,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [31:0]               m_axis_tdata,
  input  logic [0:0]                m_axis_tuser,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic [pcm_pkg::THR_W-1:0] cfg_data_i,
  output int                        pending_o,
  output int                        fails_o
);
  import pcm_pkg::*;

  typedef struct packed {
    logic [CORR_W-1:0] corr;
    logic              ok;
    logic [CNT_W-1:0]  used;
  } corr_res_t;

  corr_res_t exp_q[$];

  logic [THR_W-1:0] thr;
  longint           n_total, n_present, s_a, s_b, sq_a, sq_b, s_ab;

  assign pending_o = exp_q.size();

  // largest q in [0, Q_ONE] with (2q-1)^2 * va * vb <= num^2 * 2^30
  function automatic int ratio_q(longint unsigned anum, longint unsigned va,
                                 longint unsigned vb);
    logic [191:0] vprod, rhs, lhs;
    longint unsigned k;
    int lo, hi, mid;
    vprod = 192'(va) * 192'(vb);
    rhs   = (192'(anum) * 192'(anum)) << RHS_SHIFT;
    lo = 0;
    hi = Q_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k   = 2 * mid - 1;
      lhs = 192'(k * k) * vprod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic corr_res_t finish_series();
    corr_res_t r;
    longint num, va, vb;
    int q;
    r.corr = '0;
    r.ok   = 1'b0;
    r.used = CNT_W'(n_present);
    if (n_present >= 2 && n_present * 65536 >= longint'(thr) * n_total) begin
      num = n_present * s_ab - s_a * s_b;
      va  = n_present * sq_a - s_a * s_a;
      vb  = n_present * sq_b - s_b * s_b;
      if (va > 0 && vb > 0) begin
        q = ratio_q(num < 0 ? -num : num, va, vb);
        r.corr = num < 0 ? CORR_W'(-q) : CORR_W'(q);
        r.ok   = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint a, b;
    corr_res_t e;
    if (!rst_ni) begin
      thr = '0;
      n_total = 0; n_present = 0; s_a = 0; s_b = 0; sq_a = 0; sq_b = 0; s_ab = 0;
      exp_q.delete();
      fails_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) thr = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        a = longint'($signed(s_axis_tdata[15:0]));
        b = longint'($signed(s_axis_tdata[31:16]));
        if (n_total < MAX_SAMPLES) begin
          n_total++;
          if (!s_axis_tuser[0] && !s_axis_tuser[1]) begin
            n_present++;
            s_a += a; s_b += b; sq_a += a * a; sq_b += b * b; s_ab += a * b;
          end
        end
        if (s_axis_tlast) begin
          exp_q.push_back(finish_series());
          n_total = 0; n_present = 0; s_a = 0; s_b = 0; sq_a = 0; sq_b = 0; s_ab = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data %h user %b",
                   $time, m_axis_tdata, m_axis_tuser);
          fails_o <= fails_o + 1;
        end else begin
          e = exp_q.pop_front();
          if (m_axis_tdata[15:0] !== e.corr || m_axis_tuser[0] !== e.ok ||
              m_axis_tdata[26:16] !== e.used || m_axis_tdata[31:27] !== '0) begin
            $display("%0t: mismatch, expected corr %0d valid %0d used %0d, actual corr %0d valid %0d used %0d pad %h",
                     $time, $signed(e.corr), e.ok, e.used, $signed(m_axis_tdata[15:0]),
                     m_axis_tuser[0], m_axis_tdata[26:16], m_axis_tdata[31:27]);
            fails_o <= fails_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the correlation testbench: stimulus, receiver stalls, watchdog and verdict.
module tb;
  import pcm_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int LONG_HOLD   = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i;
  int          pending, fails, items_sent, idle_cycles;
  bit          hold_req;

  pearson_correlation_missing dut (.*);

  corr_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .pending_o(pending), .fails_o(fails)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_pair(logic [15:0] a, logic [15:0] b, bit am, bit bm, bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= {bm, am};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_thr(logic [THR_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random series; style picks how the two samples relate
  task automatic send_series(int len, int miss_pct);
    int style, span;
    logic [15:0] a, b;
    bit am, bm;
    style = $urandom_range(5);
    span  = $urandom_range(3) == 0 ? 65535 : $urandom_range(2000, 1);
    for (int i = 0; i < len; i++) begin
      a = span == 65535 ? 16'($urandom) : 16'($signed($urandom_range(2 * span)) - span);
      case (style)
        0: b = a;
        1: b = -a;
        2: b = a + 16'($urandom_range(6)) - 16'd3;
        3: b = 16'd77;
        default: b = 16'($urandom);
      endcase
      am = $urandom_range(99) < miss_pct;
      bm = $urandom_range(99) < miss_pct;
      send_pair(a, b, am, bm, i == len - 1);
    end
  endtask

  // receiver: short and long stalls, plus a long hold on request
  initial begin
    int r, n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(40, 1);
      end else begin
        m_axis_tready <= 1'b0;
        n = r < 95 ? $urandom_range(3, 1) : $urandom_range(300, 20);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int len;
    logic [THR_W-1:0] thr_set [5];
    thr_set = '{0, 49152, 65536, 131071, 32768};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0; s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    hold_req = 1'b0; idle_cycles = 0; items_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: extremes, single pair, all missing, constant series
    send_pair(16'h8000, 16'h7fff, 0, 0, 0);
    send_pair(16'h7fff, 16'h8000, 0, 0, 0);
    send_pair(16'h0000, 16'hffff, 0, 0, 1);
    send_pair(16'h1234, 16'h4321, 0, 0, 1);
    send_pair(16'h1111, 16'h2222, 1, 0, 0);
    send_pair(16'h3333, 16'h4444, 0, 1, 0);
    send_pair(16'h5555, 16'h6666, 1, 1, 1);
    send_pair(16'h0100, 16'h0200, 0, 0, 0);
    send_pair(16'h0100, 16'h0300, 0, 0, 0);
    send_pair(16'h0100, 16'h0400, 0, 0, 1);
    send_pair(16'h8000, 16'h8000, 0, 0, 0);
    send_pair(16'h7fff, 16'h7fff, 0, 0, 1);
    send_pair(16'h8000, 16'h7fff, 0, 0, 0);
    send_pair(16'h7fff, 16'h8000, 0, 0, 0);
    send_pair(16'h0000, 16'h0000, 1, 0, 1);
    // threshold of one: a single missing pair spoils it
    write_thr(17'd65536);
    send_pair(16'h0010, 16'h0020, 0, 0, 0);
    send_pair(16'h0030, 16'h0010, 0, 0, 0);
    send_pair(16'h0050, 16'h0070, 0, 0, 1);
    send_pair(16'h0010, 16'h0020, 0, 0, 0);
    send_pair(16'h0030, 16'h0010, 0, 0, 0);
    send_pair(16'h0050, 16'h0070, 1, 0, 1);
    // threshold above one never met
    write_thr(17'h1ffff);
    send_pair(16'h0010, 16'h0020, 0, 0, 0);
    send_pair(16'h0030, 16'h0010, 0, 0, 1);
    write_thr(17'd0);

    // overflow: more pairs than kept
    send_series(MAX_SAMPLES + 6, 3);

    // receiver holds off while series keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_series($urandom_range(5, 2), 10);
    drain();

    while (items_sent < 1600) begin
      if ($urandom_range(15) == 0) write_thr(thr_set[$urandom_range(4)] |
                                             ($urandom_range(3) == 0 ? 17'($urandom) : 17'd0));
      len = $urandom_range(9) == 0 ? $urandom_range(60, 20) :
            $urandom_range(6) == 0 ? 1 : $urandom_range(12, 2);
      send_series(len, $urandom_range(3) == 0 ? 40 : 8);
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
